[hdl/wddh_pkg.sv]
// shared types, constants and command/status structs for the drop detector
package wddh_pkg;

  // field widths of the payloads and registers
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned WinW   = 16;
  localparam int unsigned LimW   = 16;
  localparam int unsigned HoldW  = 20;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned CfgIdxW = 2;

  // register reset values
  localparam logic [WinW-1:0]  WindowRst = 16'd3000;
  localparam logic [LimW-1:0]  LimitRst  = 16'd40;
  localparam logic [HoldW-1:0] HoldRst   = 20'd10000;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHold   = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] StatusClear     = 2'd0;
  localparam logic [StatW-1:0] StatusTriggered = 2'd1;
  localparam logic [StatW-1:0] StatusHolding   = 2'd2;

  // input transaction, also the layout of one history entry
  typedef struct packed {
    logic [TimeW-1:0]  time_ms;
    logic [LevelW-1:0] level;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [LevelW-1:0] drop_amount;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StHoldChk,
    StAppend,
    StExpRd,
    StExpChk,
    StMaxScan,
    StDecide,
    StEmit
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic hold_clear;
    logic set_held;
    logic append;
    logic exp_read;
    logic exp_pop;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hold_hit;
    logic expired;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/wddh_ctrl.sv]
// sequencing state machine of the drop detector
module wddh_ctrl
  import wddh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StHoldChk;
      end
      StHoldChk: begin
        state_d = sts_i.hold_hit ? StEmit : StAppend;
      end
      StAppend:  state_d = StExpRd;
      StExpRd:   state_d = StExpChk;
      StExpChk: begin
        state_d = sts_i.expired ? StExpRd : StMaxScan;
      end
      StMaxScan: begin
        if (sts_i.scan_done) state_d = StDecide;
      end
      StDecide:  state_d = StEmit;
      StEmit: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default:   state_d = StIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      StHoldChk: begin
        cmd_o.set_held   = sts_i.hold_hit;
        cmd_o.hold_clear = !sts_i.hold_hit;
      end
      StAppend:  cmd_o.append = 1'b1;
      StExpRd:   cmd_o.exp_read = 1'b1;
      StExpChk: begin
        cmd_o.exp_pop    = sts_i.expired;
        cmd_o.scan_start = !sts_i.expired;
      end
      StMaxScan: cmd_o.scan_step = 1'b1;
      StDecide:  cmd_o.decide = 1'b1;
      StEmit:    cmd_o.emit = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[hdl/wddh_dp.sv]
// datapath: registers, sample history memory, window scan and output register
module wddh_dp
  import wddh_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(HISTORY_DEPTH);
  localparam logic [SumW-1:0]  DepthSum = SumW'(HISTORY_DEPTH);

  // wrapping increment of a ring address
  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] a);
    wrap_inc = (a == LastAddr) ? '0 : a + 1'b1;
  endfunction

  // configuration registers
  logic [WinW-1:0]  window_q;
  logic [LimW-1:0]  limit_q;
  logic [HoldW-1:0] hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WindowRst;
      limit_q   <= LimitRst;
      hold_ms_q <= HoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindow: window_q  <= cfg_data_i[WinW-1:0];
        CfgLimit:  limit_q   <= cfg_data_i[LimW-1:0];
        CfgHold:   hold_ms_q <= cfg_data_i[HoldW-1:0];
        default:   ;
      endcase
    end
  end

  // captured sample
  in_t smp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) smp_q <= in_data_i;
  end

  // hold state
  logic             hold_act_q;
  logic [TimeW-1:0] hold_end_q;
  logic [TimeW-1:0] remaining;
  logic [LevelW-1:0] drop;
  logic             trig;

  assign remaining = hold_end_q - smp_q.time_ms;
  assign sts_o.hold_hit = hold_act_q && (remaining != '0) && !remaining[TimeW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_act_q <= 1'b0;
      hold_end_q <= '0;
    end else if (cmd_i.hold_clear) begin
      hold_act_q <= 1'b0;
    end else if (cmd_i.decide && trig) begin
      hold_act_q <= 1'b1;
      hold_end_q <= smp_q.time_ms + TimeW'(hold_ms_q);
    end
  end

  // ring pointers
  logic [AddrW-1:0] head_q;
  logic [CntW-1:0]  count_q;
  logic [SumW-1:0]  slot_sum;
  logic [AddrW-1:0] slot;
  logic             full;

  assign full     = (count_q == FullCnt);
  assign slot_sum = SumW'(head_q) + SumW'(count_q);
  always_comb begin
    if (full) begin
      slot = head_q;
    end else if (slot_sum >= DepthSum) begin
      slot = AddrW'(slot_sum - DepthSum);
    end else begin
      slot = slot_sum[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.append) begin
      if (full) begin
        head_q <= wrap_inc(head_q);
      end else begin
        count_q <= count_q + 1'b1;
      end
    end else if (cmd_i.exp_pop) begin
      head_q  <= wrap_inc(head_q);
      count_q <= count_q - 1'b1;
    end
  end

  // scan pointers
  logic [AddrW-1:0]  ptr_q;
  logic [CntW-1:0]   left_q;
  logic              rvalid_q;
  logic [LevelW-1:0] max_q;
  logic              issue;

  assign issue = cmd_i.scan_step && (left_q != '0);
  assign sts_o.scan_done = (left_q == '0) && !rvalid_q;

  // history memory, one write and one registered read port
  in_t              mem [HISTORY_DEPTH];
  in_t              rd_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  assign rd_en   = cmd_i.exp_read || issue;
  assign rd_addr = cmd_i.exp_read ? head_q : ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) mem[slot] <= smp_q;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // age check of the oldest entry
  logic [TimeW-1:0] age;
  assign age = smp_q.time_ms - rd_q.time_ms;
  assign sts_o.expired = (age > TimeW'(window_q));

  // maximum scan over the kept entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      rvalid_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      left_q   <= count_q;
      rvalid_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (issue) left_q <= left_q - 1'b1;
      rvalid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      ptr_q <= head_q;
      max_q <= smp_q.level;
    end else if (cmd_i.scan_step) begin
      if (issue) ptr_q <= wrap_inc(ptr_q);
      if (rvalid_q && (rd_q.level > max_q)) max_q <= rd_q.level;
    end
  end

  // decision
  assign drop = max_q - smp_q.level;
  assign trig = (drop > limit_q);

  out_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_held) begin
      res_q.status      <= StatusHolding;
      res_q.drop_amount <= '0;
    end else if (cmd_i.decide) begin
      res_q.status      <= trig ? StatusTriggered : StatusClear;
      res_q.drop_amount <= drop;
    end
  end

  // output register
  logic out_valid_q;
  out_t out_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("history count above depth");

  a_append_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> (count_q != '0))
    else $error("history empty after append");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a stalled transaction");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exp_pop |-> (count_q > CntW'(1)))
    else $error("newest entry expired");

endmodule

[hdl/windowed_drop_detector_hold.sv]
// one transaction at a time: a new sample is taken only while the sequencer is idle
// the run time grows with the entries kept and the entries expired, set by the single read port
// of the history memory, through which each scanned entry and each expired entry is read
// the output register lets the next transaction in while a result waits
// reset clears control, pointers and hold state; history contents stay unset
module windowed_drop_detector_hold
  import wddh_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  wddh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath
  wddh_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
